// ----- src/pegi_pkg.sv -----
package pegi_pkg;

	localparam int VERTEX_BITS = 24;
	localparam int OUT_BITS    = VERTEX_BITS + 1;
	localparam int QUOT_BITS   = VERTEX_BITS - 1;
	localparam int PROD_BITS   = 2 * VERTEX_BITS;
	localparam int DIV_STEPS   = OUT_BITS;
	localparam int MODE_BITS   = 4;
	localparam int INDEX_BITS  = 2;

	typedef logic [VERTEX_BITS-1:0] vtx_t;
	typedef logic [OUT_BITS-1:0]    word_t;
	typedef logic [QUOT_BITS-1:0]   quot_t;
	typedef logic [PROD_BITS-1:0]   prod_t;
	typedef logic [MODE_BITS-1:0]   mode_t;
	typedef logic [INDEX_BITS-1:0]  index_t;

	localparam mode_t MODE_POINTS    = 4'd0;
	localparam mode_t MODE_LINES     = 4'd1;
	localparam mode_t MODE_LOOP      = 4'd2;
	localparam mode_t MODE_STRIP     = 4'd3;
	localparam mode_t MODE_TRIS      = 4'd4;
	localparam mode_t MODE_TSTRIP    = 4'd5;
	localparam mode_t MODE_FAN       = 4'd6;
	localparam mode_t MODE_QUADS     = 4'd7;
	localparam mode_t MODE_QSTRIP    = 4'd8;
	localparam mode_t MODE_POLYGON   = 4'd9;
	localparam mode_t MODE_RESET     = MODE_TRIS;

	localparam index_t REG_TOPOLOGY = 2'd0;
	localparam index_t REG_VERTEX   = 2'd1;

	// floor(x/3) == (x * RECIP3) >> OUT_BITS for every x below 2**VERTEX_BITS
	localparam logic [63:0] RECIP3_FULL = ((64'd1 << OUT_BITS) + 64'd2) / 64'd3;
	localparam vtx_t        RECIP3      = RECIP3_FULL[VERTEX_BITS-1:0];

	typedef struct packed {
		mode_t mode;
		vtx_t  vtotal;
	} cfg_t;

	typedef struct packed {
		word_t first;
		word_t second;
		word_t edges;
		logic  wrap;
		logic  vzero;
		vtx_t  rem;
		word_t num;
	} stage_t;

endpackage

// ----- src/pegi_front.sv -----
module pegi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pegi_pkg::vtx_t    edge_number,
	input  pegi_pkg::cfg_t    cfg,
	input  logic              down_en,
	output logic              out_valid,
	output pegi_pkg::stage_t  out_stage
);

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	pegi_pkg::vtx_t   i_s1, i_s2;
	pegi_pkg::quot_t  qi_s2, qv_s2;
	pegi_pkg::stage_t stg_s3;

	pegi_pkg::prod_t  prod_i, prod_v;

	pegi_pkg::word_t  iw, ip1, vw, qiw, qvw, q3x, mfull, face2, face8, a, b, e;
	logic [1:0]       m3, mp2;
	logic             odd, i_zero, vzero, wrap, nz;
	pegi_pkg::stage_t nxt;

	assign en3      = !vld_s3 || down_en;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	assign prod_i = pegi_pkg::prod_t'(i_s1) * pegi_pkg::prod_t'(pegi_pkg::RECIP3);
	assign prod_v = pegi_pkg::prod_t'(cfg.vtotal) * pegi_pkg::prod_t'(pegi_pkg::RECIP3);

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			i_s1 <= edge_number;
		end
		if (en2 && vld_s1) begin
			i_s2  <= i_s1;
			qi_s2 <= prod_i[pegi_pkg::PROD_BITS-1:pegi_pkg::OUT_BITS];
			qv_s2 <= prod_v[pegi_pkg::PROD_BITS-1:pegi_pkg::OUT_BITS];
		end
		if (en3 && vld_s2) begin
			stg_s3 <= nxt;
		end
	end

	always_comb begin
		iw     = pegi_pkg::word_t'(i_s2);
		ip1    = iw + pegi_pkg::word_t'(1);
		vw     = pegi_pkg::word_t'(cfg.vtotal);
		qiw    = pegi_pkg::word_t'(qi_s2);
		qvw    = pegi_pkg::word_t'(qv_s2);
		q3x    = qiw + (qiw << 1);
		mfull  = iw - q3x;
		m3     = mfull[1:0];
		odd    = i_s2[0];
		i_zero = (i_s2 == '0);
		vzero  = (cfg.vtotal == '0);
		nz     = (m3 != 2'd0);
		face2  = (iw - pegi_pkg::word_t'(1)) >> 1;
		face8  = nz ? qiw : qiw - pegi_pkg::word_t'(1);
		case (m3)
			2'd0:    mp2 = 2'd2;
			2'd1:    mp2 = 2'd0;
			default: mp2 = 2'd1;
		endcase
		a    = '0;
		b    = '0;
		e    = '0;
		wrap = 1'b0;
		case (cfg.mode)
			pegi_pkg::MODE_POINTS: begin
				a = iw;
				b = iw;
			end
			pegi_pkg::MODE_LINES: begin
				a = iw << 1;
				b = (iw << 1) | pegi_pkg::word_t'(1);
				e = vw >> 1;
			end
			pegi_pkg::MODE_LOOP, pegi_pkg::MODE_POLYGON: begin
				a    = iw;
				wrap = 1'b1;
				e    = vw;
			end
			pegi_pkg::MODE_STRIP: begin
				a = iw;
				b = ip1;
				e = vzero ? '0 : vw - pegi_pkg::word_t'(1);
			end
			pegi_pkg::MODE_TRIS: begin
				a = iw;
				b = (m3 == 2'd2) ? iw - pegi_pkg::word_t'(2) : ip1;
				e = qvw;
			end
			pegi_pkg::MODE_TSTRIP: begin
				if (i_zero) begin
					b = pegi_pkg::word_t'(1);
				end else begin
					a = face2 + pegi_pkg::word_t'({!odd, 1'b0})
						+ pegi_pkg::word_t'(!face2[0] && odd);
					b = face2 + pegi_pkg::word_t'({odd, 1'b0})
						+ pegi_pkg::word_t'(face2[0] && !odd);
				end
				e = vw - qvw + pegi_pkg::word_t'(1);
			end
			pegi_pkg::MODE_FAN: begin
				if (i_zero) begin
					b = pegi_pkg::word_t'(1);
				end else begin
					a = face2 + pegi_pkg::word_t'(2) - pegi_pkg::word_t'(odd);
					b = odd ? face2 + pegi_pkg::word_t'(2) : '0;
				end
				e = vw - qvw + pegi_pkg::word_t'(1);
			end
			pegi_pkg::MODE_QUADS: begin
				a = iw;
				b = (i_s2[1:0] == 2'b11) ? iw - pegi_pkg::word_t'(3) : ip1;
				e = vw >> 2;
			end
			pegi_pkg::MODE_QSTRIP: begin
				if (i_zero) begin
					b = pegi_pkg::word_t'(1);
				end else begin
					a = (face8 << 1) + pegi_pkg::word_t'(m3) + pegi_pkg::word_t'(mp2);
					b = (face8 << 1) + (nz ? pegi_pkg::word_t'(4) : '0)
						- pegi_pkg::word_t'(m3);
				end
				e = vw - (vw >> 2) + pegi_pkg::word_t'(1);
			end
			default: begin
				a = '0;
				b = '0;
				e = '0;
			end
		endcase
		nxt.first  = a;
		nxt.second = b;
		nxt.edges  = e;
		nxt.wrap   = wrap;
		nxt.vzero  = vzero;
		nxt.rem    = '0;
		nxt.num    = ip1;
	end

	assign out_valid = vld_s3;
	assign out_stage = stg_s3;

endmodule

// ----- src/pegi_div_step.sv -----
module pegi_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pegi_pkg::stage_t  in_stage,
	input  pegi_pkg::vtx_t    divisor,
	input  logic              down_en,
	output logic              up_en,
	output logic              out_valid,
	output pegi_pkg::stage_t  out_stage
);

	logic             vld_s1;
	pegi_pkg::stage_t stg_s1;

	logic             en, ge;
	pegi_pkg::word_t  r2, dw, rn;
	pegi_pkg::stage_t nxt;

	assign en    = !vld_s1 || down_en;
	assign up_en = en;

	always_comb begin
		r2       = {in_stage.rem, in_stage.num[pegi_pkg::OUT_BITS-1]};
		dw       = pegi_pkg::word_t'(divisor);
		ge       = (r2 >= dw);
		rn       = ge ? r2 - dw : r2;
		nxt      = in_stage;
		nxt.rem  = rn[pegi_pkg::VERTEX_BITS-1:0];
		nxt.num  = {in_stage.num[pegi_pkg::OUT_BITS-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			stg_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_stage = stg_s1;

endmodule

// ----- src/primitive_edge_index_generator_top.sv -----
// Primitive edge index generator.
// Configuration: write cfg_index 0 (topology, low 4 bits of cfg_data) or
// cfg_index 1 (vertex count) with cfg_valid; cfg_ready is always high.
// Write configuration only while no edge is in flight.
// Input channel: in_valid/in_ready with edge_number. Output channel:
// out_valid/out_ready with first_vertex, second_vertex and edges_in_mesh.
// Pipeline: three front stages (input register, reciprocal multiply for
// the divide-by-three, per-topology select), 25 one-bit restoring divide
// steps that form the loop and polygon wrap modulo, and the output
// register.
// Throughput: one beat per cycle in and out while out_ready stays high.
// A stalled receiver holds the output register; each stage keeps taking
// beats while it has a bubble ahead of it, so intake stops only once the
// whole pipeline is full. Nothing is dropped or repeated.
// Reset clears every stage valid bit and sets topology to triangles and
// the vertex count to zero.
module primitive_edge_index_generator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  pegi_pkg::index_t    cfg_index,
	input  pegi_pkg::vtx_t      cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  pegi_pkg::vtx_t      edge_number,
	output logic                out_valid,
	input  logic                out_ready,
	output pegi_pkg::word_t     first_vertex,
	output pegi_pkg::word_t     second_vertex,
	output pegi_pkg::word_t     edges_in_mesh
);

	pegi_pkg::mode_t  topology_q;
	pegi_pkg::vtx_t   vtotal_q;
	pegi_pkg::cfg_t   cfg;

	logic [pegi_pkg::DIV_STEPS:0] chain_vld;
	logic [pegi_pkg::DIV_STEPS:0] chain_en;
	pegi_pkg::stage_t             chain_stg [pegi_pkg::DIV_STEPS+1];

	logic             out_valid_q;
	logic             out_en;
	pegi_pkg::word_t  first_q, second_q, edges_q;
	pegi_pkg::stage_t last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topology_q <= pegi_pkg::MODE_RESET;
			vtotal_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pegi_pkg::REG_TOPOLOGY: topology_q <= cfg_data[pegi_pkg::MODE_BITS-1:0];
				pegi_pkg::REG_VERTEX:   vtotal_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.mode   = topology_q;
	assign cfg.vtotal = vtotal_q;

	pegi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.edge_number (edge_number),
		.cfg         (cfg),
		.down_en     (chain_en[0]),
		.out_valid   (chain_vld[0]),
		.out_stage   (chain_stg[0])
	);

	for (genvar k = 0; k < pegi_pkg::DIV_STEPS; k++) begin : g_div
		pegi_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_vld[k]),
			.in_stage  (chain_stg[k]),
			.divisor   (vtotal_q),
			.down_en   (chain_en[k+1]),
			.up_en     (chain_en[k]),
			.out_valid (chain_vld[k+1]),
			.out_stage (chain_stg[k+1])
		);
	end

	assign last   = chain_stg[pegi_pkg::DIV_STEPS];
	assign out_en = !out_valid_q || out_ready;
	assign chain_en[pegi_pkg::DIV_STEPS] = out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= chain_vld[pegi_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && chain_vld[pegi_pkg::DIV_STEPS]) begin
			first_q <= last.first;
			edges_q <= last.edges;
			if (last.wrap) begin
				second_q <= last.vzero ? '0 : pegi_pkg::word_t'(last.rem);
			end else begin
				second_q <= last.second;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign first_vertex  = first_q;
	assign second_vertex = second_q;
	assign edges_in_mesh = edges_q;

	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output register empty");

	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		chain_vld[pegi_pkg::DIV_STEPS] && !chain_en[pegi_pkg::DIV_STEPS]
		|=> chain_vld[pegi_pkg::DIV_STEPS] && $stable(chain_stg[pegi_pkg::DIV_STEPS]))
		else $error("last divide stage changed while stalled");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(chain_vld[pegi_pkg::DIV_STEPS]))
		else $error("output beat without a beat in the last stage");

endmodule
